/* hdl/bsa_pkg.sv */
package bsa_pkg;

  localparam int SLOTS        = 64;
  localparam int WORD_W       = 32;
  localparam int WORD_BIT_W   = 5;
  localparam int MAP_WORDS    = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WORD_IDX_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SLOT_NUM_W   = WORD_IDX_W + WORD_BIT_W;
  localparam int CMD_W        = 2;
  localparam int CNT_W        = 7;
  localparam int TGT_W        = 7;
  localparam int SLOT_INDEX_W = 6;
  localparam int CMP_W        = (SLOT_NUM_W + 1 > CNT_W) ? SLOT_NUM_W + 1 : CNT_W;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);
  localparam logic             ST_OK       = 1'b0;
  localparam logic             ST_NO_FREE  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_FIRST = 2'd1,
    CMD_NEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    WC_HOLD,
    WC_ZERO,
    WC_INC,
    WC_DEC
  } wc_op_e;

  typedef struct packed {
    logic   load;
    wc_op_e wc_op;
    logic   init_wr;
    logic   take_up;
    logic   take_dn;
    logic   res_zero_ok;
    logic   res_fail;
    logic   out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic up_hit;
    logic dn_hit;
    logic wcnt_top;
    logic wcnt_zero;
    logic out_busy;
  } dp_sts_t;

endpackage

/* hdl/alloc_req_if.sv */
interface alloc_req_if
  import bsa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [TGT_W-1:0] target_slot;

  modport source (output valid, command, target_slot, input ready);
  modport sink (input valid, command, target_slot, output ready);
endinterface

/* hdl/alloc_rsp_if.sv */
interface alloc_rsp_if
  import bsa_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic                    status;

  modport source (output valid, slot_index, status, input ready);
  modport sink (input valid, slot_index, status, output ready);
endinterface

/* hdl/cfg_wr_if.sv */
interface cfg_wr_if
  import bsa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] slot_count;

  modport source (output valid, slot_count, input ready);
  modport sink (input valid, slot_count, output ready);
endinterface

/* hdl/bsa_datapath.sv */
module bsa_datapath
  import bsa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_ctl_t                 ctl_i,
  output dp_sts_t                 sts_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [TGT_W-1:0]        target_slot_i,
  input  logic                    cfg_valid_i,
  input  logic [CNT_W-1:0]        cfg_count_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic [SLOT_INDEX_W-1:0] slot_index_o,
  output logic                    status_o
);

  logic [WORD_W-1:0]     map_q [MAP_WORDS];
  logic [CNT_W-1:0]      count_q;
  logic [WORD_IDX_W-1:0] wcnt_q, wcnt_d;
  logic [CMP_W-1:0]      lo_q, lo_d;
  logic [CMP_W-1:0]      hi_q, hi_d;
  logic [CMP_W-1:0]      res_slot_q, res_slot_d;
  logic                  res_status_q, res_status_d;
  logic                  out_valid_q;
  logic [SLOT_INDEX_W-1:0] out_slot_q;
  logic                  out_status_q;

  logic [CMP_W-1:0]      n_c;
  logic [CMP_W-1:0]      tgt_c;
  logic [WORD_W-1:0]     word_c;
  logic [WORD_W-1:0]     up_vec, dn_vec, init_word;
  logic                  up_hit, dn_hit;
  logic [WORD_BIT_W-1:0] up_idx, dn_idx;

  assign n_c    = (CMP_W'(count_q) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(count_q);
  assign tgt_c  = CMP_W'(target_slot_i);
  assign word_c = map_q[wcnt_q];

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      logic [CMP_W-1:0] s;
      logic             fr;
      s            = CMP_W'({wcnt_q, WORD_BIT_W'(b)});
      fr           = !word_c[b] && (s < n_c);
      up_vec[b]    = fr && (s >= lo_q);
      dn_vec[b]    = fr && (s <= hi_q);
      init_word[b] = (s >= n_c);
    end
  end

  always_comb begin
    up_hit = 1'b0;
    up_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (up_vec[b]) begin
        up_hit = 1'b1;
        up_idx = WORD_BIT_W'(b);
      end
    end
  end

  always_comb begin
    dn_hit = 1'b0;
    dn_idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (dn_vec[b]) begin
        dn_hit = 1'b1;
        dn_idx = WORD_BIT_W'(b);
      end
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctl_i.load) begin
      if (command_i == CMD_FIRST) begin
        lo_d = '0;
        hi_d = '0;
      end else if (tgt_c >= n_c) begin
        lo_d = n_c;
        hi_d = n_c - CMP_W'(1);
      end else begin
        lo_d = tgt_c;
        hi_d = tgt_c;
      end
    end
  end

  always_comb begin
    case (ctl_i.wc_op)
      WC_ZERO: wcnt_d = '0;
      WC_INC:  wcnt_d = wcnt_q + WORD_IDX_W'(1);
      WC_DEC:  wcnt_d = wcnt_q - WORD_IDX_W'(1);
      default: wcnt_d = wcnt_q;
    endcase
  end

  always_comb begin
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    if (ctl_i.take_up) begin
      res_slot_d   = CMP_W'({wcnt_q, up_idx});
      res_status_d = ST_OK;
    end else if (ctl_i.take_dn) begin
      res_slot_d   = CMP_W'({wcnt_q, dn_idx});
      res_status_d = ST_OK;
    end else if (ctl_i.res_zero_ok) begin
      res_slot_d   = '0;
      res_status_d = ST_OK;
    end else if (ctl_i.res_fail) begin
      res_slot_d   = '0;
      res_status_d = ST_NO_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= '0;
      end
      count_q     <= COUNT_RESET;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_count_i;
      end
      if (ctl_i.init_wr) begin
        map_q[wcnt_q] <= init_word;
      end else if (ctl_i.take_up) begin
        map_q[wcnt_q] <= word_c | (WORD_W'(1) << up_idx);
      end else if (ctl_i.take_dn) begin
        map_q[wcnt_q] <= word_c | (WORD_W'(1) << dn_idx);
      end
      wcnt_q <= wcnt_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    if (ctl_i.out_load) begin
      out_slot_q   <= res_slot_q[SLOT_INDEX_W-1:0];
      out_status_q <= res_status_q;
    end
  end

  assign sts_o.up_hit    = up_hit;
  assign sts_o.dn_hit    = dn_hit;
  assign sts_o.wcnt_top  = (wcnt_q == WORD_IDX_W'(MAP_WORDS - 1));
  assign sts_o.wcnt_zero = (wcnt_q == '0);
  assign sts_o.out_busy  = out_valid_q && !rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign slot_index_o = out_slot_q;
  assign status_o     = out_status_q;

endmodule

/* hdl/bsa_ctrl.sv */
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [CMD_W-1:0] command_i,
  input  dp_sts_t          sts_i,
  output logic             req_ready_o,
  output dp_ctl_t          ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_UP,
    S_DOWN,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   near_q, near_d;

  always_comb begin
    state_d     = state_q;
    near_d      = near_q;
    req_ready_o = 1'b0;
    ctl_o       = '0;
    ctl_o.wc_op = WC_HOLD;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctl_o.load  = 1'b1;
          ctl_o.wc_op = WC_ZERO;
          case (command_i)
            CMD_INIT: begin
              ctl_o.res_zero_ok = 1'b1;
              state_d           = S_INIT;
            end
            CMD_FIRST: begin
              near_d  = 1'b0;
              state_d = S_UP;
            end
            CMD_NEAR: begin
              near_d  = 1'b1;
              state_d = S_UP;
            end
            default: begin
              ctl_o.res_fail = 1'b1;
              state_d        = S_RESULT;
            end
          endcase
        end
      end
      S_INIT: begin
        ctl_o.init_wr = 1'b1;
        if (sts_i.wcnt_top) begin
          state_d = S_RESULT;
        end else begin
          ctl_o.wc_op = WC_INC;
        end
      end
      S_UP: begin
        if (sts_i.up_hit) begin
          ctl_o.take_up = 1'b1;
          state_d       = S_RESULT;
        end else if (!sts_i.wcnt_top) begin
          ctl_o.wc_op = WC_INC;
        end else if (near_q) begin
          state_d = S_DOWN;
        end else begin
          ctl_o.res_fail = 1'b1;
          state_d        = S_RESULT;
        end
      end
      S_DOWN: begin
        if (sts_i.dn_hit) begin
          ctl_o.take_dn = 1'b1;
          state_d       = S_RESULT;
        end else if (sts_i.wcnt_zero) begin
          ctl_o.res_fail = 1'b1;
          state_d        = S_RESULT;
        end else begin
          ctl_o.wc_op = WC_DEC;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      near_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      near_q  <= near_d;
    end
  end

endmodule

/* hdl/bitmap_slot_allocator_unit.sv */
// channel  | dir | word                      | accepted when
// req_i    | in  | command, target_slot      | req_i.valid & req_i.ready
// rsp_o    | out | slot_index, status        | rsp_o.valid & rsp_o.ready
// cfg_i    | in  | slot_count                | cfg_i.valid & cfg_i.ready
//
// One request at a time; the used map is scanned one 32-bit word per cycle.
// Init writes every map word in order; allocate lowest scans up from word 0;
// allocate near scans up for the target or above, then down from the top word.
// The result sits in an output register; the next request is taken while it waits.
// Reset clears the map flops and sets slot_count to 64; cfg_i is always ready.
module bitmap_slot_allocator_unit
  import bsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  alloc_req_if.sink   req_i,
  alloc_rsp_if.source rsp_o,
  cfg_wr_if.sink      cfg_i
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_i.ready = 1'b1;

  bsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .command_i   (req_i.command),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .ctl_o       (ctl)
  );

  bsa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (req_i.command),
    .target_slot_i (req_i.target_slot),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_count_i   (cfg_i.slot_count),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .slot_index_o  (rsp_o.slot_index),
    .status_o      (rsp_o.status)
  );

endmodule

/* hdl/bsa_checker.sv */
module bsa_checker
  import bsa_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [SLOT_INDEX_W-1:0] slot_index_i,
  input logic                    status_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(slot_index_i) && $stable(status_i))
    else $error("response word changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_NO_FREE) |-> slot_index_i == '0)
    else $error("no-free response with nonzero slot");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  a_rsp_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response without request in flight");

endmodule

bind bitmap_slot_allocator_unit bsa_checker u_bsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .slot_index_i (rsp_o.slot_index),
  .status_i     (rsp_o.status)
);
